>>> src/h264rtp_pkg.sv
// Shared types and constants of the H.264 RTP packetizer.
// No dependencies; every other file of the block imports this package.
package h264rtp_pkg;

   localparam int NAL_LENGTH_BITS = 22;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] INTERLEAVE_MAGIC = 8'h24;   // '$'
   localparam logic [7:0] INTERLEAVE_CHAN  = 8'h00;
   localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
   localparam logic [4:0] FU_A_TYPE        = 5'd28;
   localparam logic [4:0] RTP_HDR_LEN      = 5'd12;
   localparam logic [4:0] FU_HDR_LEN       = 5'd2;
   localparam logic [4:0] INTERLEAVE_LEN   = 5'd4;

   localparam logic [1:0] CSR_MAX_PACKET_SIZE = 2'd0;
   localparam logic [1:0] CSR_TCP_INTERLEAVED = 2'd1;
   localparam logic [1:0] CSR_SSRC            = 2'd2;
   localparam logic [1:0] CSR_PAYLOAD_TYPE    = 2'd3;

   typedef struct packed {
      logic [15:0] max_packet_size;
      logic        tcp_interleaved;
      logic [31:0] ssrc;
      logic [6:0]  payload_type;
   } cfg_type;

   // One unit of work for the back end: optional headers plus one payload byte.
   typedef struct packed {
      logic        has_hdr;
      logic        has_fu;
      logic        marker;
      logic [15:0] seq;
      logic [31:0] ts;
      logic [15:0] rtp_len;
      logic [7:0]  fu_ind;
      logic [7:0]  fu_hdr;
      logic [7:0]  data;
      logic        data_end;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

>>> src/h264rtp_if.sv
// Valid/ready channel interfaces for the input and result items of the packetizer.
// Depends on h264rtp_pkg for the NAL length width.
interface h264rtp_req_if;
   import h264rtp_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [7:0]                 nal_byte;
   logic [NAL_LENGTH_BITS-1:0] nal_length;
   logic                       first_of_nal;
   logic [31:0]                timestamp;

   modport source (output valid, nal_byte, nal_length, first_of_nal, timestamp,
                   input ready);
   modport sink   (input valid, nal_byte, nal_length, first_of_nal, timestamp,
                   output ready);
endinterface

interface h264rtp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       packet_end;
   logic       last_of_run;

   modport source (output valid, out_byte, packet_end, last_of_run, input ready);
   modport sink   (input valid, out_byte, packet_end, last_of_run, output ready);
endinterface

>>> src/h264rtp_front.sv
// Front end: accepts NAL bytes, tracks packet and fragment state, and builds jobs.
// Depends on h264rtp_pkg and h264rtp_req_if.
module h264rtp_front (
   input  logic                  clock,
   input  logic                  reset,
   h264rtp_req_if.sink           req_ch,
   input  h264rtp_pkg::cfg_type  cfg,
   input  h264rtp_pkg::q_status_type q_status,
   output logic                  push,
   output h264rtp_pkg::job_type  push_job
);
   import h264rtp_pkg::*;

   logic [15:0]                seq_ff, seq_in;
   logic [NAL_LENGTH_BITS-1:0] nbl_ff, nbl_in;
   logic [15:0]                fbl_ff, fbl_in;
   logic                       frag_ff, frag_in;
   logic                       ffp_ff, ffp_in;
   logic [7:0]                 fu_ind_ff, fu_ind_in;
   logic [4:0]                 type_ff, type_in;
   logic [31:0]                ts_ff, ts_in;

   logic                       accept;
   logic [NAL_LENGTH_BITS-1:0] len_eff;
   logic [NAL_LENGTH_BITS-1:0] nbl_dec;
   logic [4:0]                 whole_overhead;
   logic [4:0]                 frag_overhead;
   logic [NAL_LENGTH_BITS:0]   fit_sum;
   logic                       fits;
   logic [15:0]                room;
   logic                       last_frag;
   logic [15:0]                fbl_new;
   logic [15:0]                fbl_eff;
   logic [15:0]                fbl_dec;

   assign req_ch.ready = !q_status.full;
   assign accept       = req_ch.valid && !q_status.full;

   always_comb begin
      len_eff        = (req_ch.nal_length == '0) ? NAL_LENGTH_BITS'(1) : req_ch.nal_length;
      whole_overhead = RTP_HDR_LEN + (cfg.tcp_interleaved ? INTERLEAVE_LEN : 5'd0);
      frag_overhead  = whole_overhead + FU_HDR_LEN;
      fit_sum        = {1'b0, len_eff} + (NAL_LENGTH_BITS+1)'(whole_overhead);
      fits           = fit_sum <= (NAL_LENGTH_BITS+1)'(cfg.max_packet_size);
      room           = (cfg.max_packet_size > 16'(frag_overhead)) ?
                       cfg.max_packet_size - 16'(frag_overhead) : 16'd1;
      last_frag      = nbl_ff <= NAL_LENGTH_BITS'(room);
      fbl_new        = last_frag ? nbl_ff[15:0] : room;
      fbl_eff        = (fbl_ff == 16'd0) ? fbl_new : fbl_ff;
      fbl_dec        = fbl_eff - 16'd1;
      nbl_dec        = nbl_ff - NAL_LENGTH_BITS'(1);
   end

   always_comb begin
      seq_in    = seq_ff;
      nbl_in    = nbl_ff;
      fbl_in    = fbl_ff;
      frag_in   = frag_ff;
      ffp_in    = ffp_ff;
      fu_ind_in = fu_ind_ff;
      type_in   = type_ff;
      ts_in     = ts_ff;
      push      = 1'b0;
      push_job  = '0;
      push_job.data = req_ch.nal_byte;

      if (accept) begin
         if (req_ch.first_of_nal) begin
            ts_in  = req_ch.timestamp;
            nbl_in = len_eff - NAL_LENGTH_BITS'(1);
            fbl_in = 16'd0;
            if (fits) begin
               // Whole NAL in a single packet with the marker set.
               frag_in = 1'b0;
               ffp_in  = 1'b0;
               seq_in  = seq_ff + 16'd1;
               push    = 1'b1;
               push_job.has_hdr  = 1'b1;
               push_job.marker   = 1'b1;
               push_job.seq      = seq_ff + 16'd1;
               push_job.ts       = req_ch.timestamp;
               push_job.rtp_len  = len_eff[15:0] + 16'(RTP_HDR_LEN);
               push_job.data_end = (len_eff == NAL_LENGTH_BITS'(1));
            end else begin
               // The NAL header byte is folded into the FU indicator and FU header.
               frag_in   = 1'b1;
               ffp_in    = 1'b1;
               fu_ind_in = {req_ch.nal_byte[7:5], FU_A_TYPE};
               type_in   = req_ch.nal_byte[4:0];
            end
         end else if (nbl_ff != '0) begin
            nbl_in = nbl_dec;
            push   = 1'b1;
            if (!frag_ff) begin
               push_job.data_end = (nbl_dec == '0);
            end else begin
               if (fbl_ff == 16'd0) begin
                  ffp_in = 1'b0;
                  seq_in = seq_ff + 16'd1;
                  push_job.has_hdr = 1'b1;
                  push_job.has_fu  = 1'b1;
                  push_job.marker  = last_frag;
                  push_job.seq     = seq_ff + 16'd1;
                  push_job.ts      = ts_ff;
                  push_job.rtp_len = fbl_new + 16'(RTP_HDR_LEN) + 16'(FU_HDR_LEN);
                  push_job.fu_ind  = fu_ind_ff;
                  push_job.fu_hdr  = {ffp_ff, last_frag, 1'b0, type_ff};
               end
               fbl_in = fbl_dec;
               push_job.data_end = (fbl_dec == 16'd0);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff    <= '0;
         nbl_ff    <= '0;
         fbl_ff    <= '0;
         frag_ff   <= 1'b0;
         ffp_ff    <= 1'b0;
         fu_ind_ff <= '0;
         type_ff   <= '0;
         ts_ff     <= '0;
      end else begin
         seq_ff    <= seq_in;
         nbl_ff    <= nbl_in;
         fbl_ff    <= fbl_in;
         frag_ff   <= frag_in;
         ffp_ff    <= ffp_in;
         fu_ind_ff <= fu_ind_in;
         type_ff   <= type_in;
         ts_ff     <= ts_in;
      end
   end

endmodule

>>> src/h264rtp_queue.sv
// Short job queue that decouples the front end from the byte serializer.
// Depends on h264rtp_pkg for the job type and queue depth.
module h264rtp_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  h264rtp_pkg::job_type      push_job,
   input  logic                      pop,
   output h264rtp_pkg::job_type      head_job,
   output h264rtp_pkg::q_status_type q_status
);
   import h264rtp_pkg::*;

   job_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;

   assign head_job       = entry_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (QUEUE_PTR_W+1)'(push) - (QUEUE_PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> src/h264rtp_back.sv
// Back end: serializes queued jobs into packet bytes through an output register.
// Depends on h264rtp_pkg and h264rtp_rsp_if.
module h264rtp_back (
   input  logic                      clock,
   input  logic                      reset,
   input  h264rtp_pkg::cfg_type      cfg,
   input  h264rtp_pkg::job_type      head_job,
   input  h264rtp_pkg::q_status_type q_status,
   output logic                      pop,
   h264rtp_rsp_if.source             rsp_ch
);
   import h264rtp_pkg::*;

   // Byte positions within one job; a job starts at the first header it carries.
   localparam logic [4:0] POS_IL_MAGIC = 5'd0;
   localparam logic [4:0] POS_IL_CHAN  = 5'd1;
   localparam logic [4:0] POS_IL_LEN_H = 5'd2;
   localparam logic [4:0] POS_IL_LEN_L = 5'd3;
   localparam logic [4:0] POS_RTP_VER  = 5'd4;
   localparam logic [4:0] POS_RTP_PT   = 5'd5;
   localparam logic [4:0] POS_SEQ_H    = 5'd6;
   localparam logic [4:0] POS_SEQ_L    = 5'd7;
   localparam logic [4:0] POS_TS_3     = 5'd8;
   localparam logic [4:0] POS_TS_2     = 5'd9;
   localparam logic [4:0] POS_TS_1     = 5'd10;
   localparam logic [4:0] POS_TS_0     = 5'd11;
   localparam logic [4:0] POS_SSRC_3   = 5'd12;
   localparam logic [4:0] POS_SSRC_2   = 5'd13;
   localparam logic [4:0] POS_SSRC_1   = 5'd14;
   localparam logic [4:0] POS_SSRC_0   = 5'd15;
   localparam logic [4:0] POS_FU_IND   = 5'd16;
   localparam logic [4:0] POS_FU_HDR   = 5'd17;
   localparam logic [4:0] POS_DATA     = 5'd18;

   logic       active_ff, active_in;
   logic [4:0] pos_ff, pos_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       end_ff, end_in;
   logic       last_ff, last_in;

   logic [4:0] start_pos;
   logic [4:0] cur_pos;
   logic [4:0] next_pos;
   logic       have_job;
   logic       out_free;
   logic       emit;
   logic [7:0] cur_byte;

   always_comb begin
      if (!head_job.has_hdr) begin
         start_pos = POS_DATA;
      end else if (cfg.tcp_interleaved) begin
         start_pos = POS_IL_MAGIC;
      end else begin
         start_pos = POS_RTP_VER;
      end
      cur_pos  = active_ff ? pos_ff : start_pos;
      next_pos = (cur_pos == POS_SSRC_0 && !head_job.has_fu) ? POS_DATA : cur_pos + 5'd1;
      have_job = active_ff || !q_status.empty;
      out_free = !valid_ff || rsp_ch.ready;
      emit     = have_job && out_free;
      pop      = emit && (cur_pos == POS_DATA);
   end

   always_comb begin
      unique case (cur_pos)
         POS_IL_MAGIC: cur_byte = INTERLEAVE_MAGIC;
         POS_IL_CHAN:  cur_byte = INTERLEAVE_CHAN;
         POS_IL_LEN_H: cur_byte = head_job.rtp_len[15:8];
         POS_IL_LEN_L: cur_byte = head_job.rtp_len[7:0];
         POS_RTP_VER:  cur_byte = RTP_VERSION_BYTE;
         POS_RTP_PT:   cur_byte = {head_job.marker, cfg.payload_type};
         POS_SEQ_H:    cur_byte = head_job.seq[15:8];
         POS_SEQ_L:    cur_byte = head_job.seq[7:0];
         POS_TS_3:     cur_byte = head_job.ts[31:24];
         POS_TS_2:     cur_byte = head_job.ts[23:16];
         POS_TS_1:     cur_byte = head_job.ts[15:8];
         POS_TS_0:     cur_byte = head_job.ts[7:0];
         POS_SSRC_3:   cur_byte = cfg.ssrc[31:24];
         POS_SSRC_2:   cur_byte = cfg.ssrc[23:16];
         POS_SSRC_1:   cur_byte = cfg.ssrc[15:8];
         POS_SSRC_0:   cur_byte = cfg.ssrc[7:0];
         POS_FU_IND:   cur_byte = head_job.fu_ind;
         POS_FU_HDR:   cur_byte = head_job.fu_hdr;
         POS_DATA:     cur_byte = head_job.data;
         default:      cur_byte = head_job.data;
      endcase
   end

   always_comb begin
      active_in = active_ff;
      pos_in    = pos_ff;
      valid_in  = rsp_ch.ready ? 1'b0 : valid_ff;
      byte_in   = byte_ff;
      end_in    = end_ff;
      last_in   = last_ff;
      if (emit) begin
         active_in = (cur_pos != POS_DATA);
         pos_in    = next_pos;
         valid_in  = 1'b1;
         byte_in   = cur_byte;
         end_in    = (cur_pos == POS_DATA) && head_job.data_end;
         last_in   = (cur_pos == POS_DATA);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pos_ff    <= POS_DATA;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         pos_ff    <= pos_in;
         valid_ff  <= valid_in;
      end
      byte_ff <= byte_in;
      end_ff  <= end_in;
      last_ff <= last_in;
   end

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.out_byte    = byte_ff;
   assign rsp_ch.packet_end  = end_ff;
   assign rsp_ch.last_of_run = last_ff;

endmodule

>>> src/h264_rtp_packetizer_core.sv
// Top level of the H.264 RTP packetizer: configuration registers, front end,
// job queue and byte serializer. Depends on h264rtp_pkg, the channel
// interfaces, h264rtp_front, h264rtp_queue and h264rtp_back.
//
// Usage: NAL bytes enter on req_ch, header byte first, with first_of_nal,
// nal_length and timestamp valid on the first byte of each NAL. Packet bytes
// leave on rsp_ch in network order; packet_end flags the last byte of each
// packet and last_of_run the last byte caused by one input item. Registers
// are written through csr_write_enable, csr_index and csr_write_data; the
// user must write them only while the block is idle, which the block itself
// does not enforce. An accepted item is written into the job queue; the back
// end then takes it from the queue head and registers its bytes in the output
// register. A payload-only item yields one output byte; an item that opens a
// packet yields 13 to 19 bytes (RTP header, optional 4-byte interleave header,
// optional 2-byte FU-A header, then the payload byte).
// Throughput is one result byte per cycle while rsp_ch.ready stays high, set
// by the single-byte output register; the four-entry job queue keeps accepting
// items while headers are being serialized, so input stalls only when the
// queue fills.
// Reset clears the packet state, the queue and the output valid flag and loads
// the register defaults. When the receiver stalls, the output byte holds and
// the queue fills, after which req_ch.ready drops.
module h264_rtp_packetizer_core (
   input  logic                 clock,
   input  logic                 reset,
   h264rtp_req_if.sink          req_ch,
   h264rtp_rsp_if.source        rsp_ch,
   input  logic                 csr_write_enable,
   input  logic [1:0]           csr_index,
   input  logic [31:0]          csr_write_data
);
   import h264rtp_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   q_status_type q_status;
   job_type      push_job;
   job_type      head_job;
   logic         push;
   logic         pop;

   // Register writes; each register keeps the low bits of the written word.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MAX_PACKET_SIZE: cfg_in.max_packet_size = csr_write_data[15:0];
            CSR_TCP_INTERLEAVED: cfg_in.tcp_interleaved = csr_write_data[0];
            CSR_SSRC:            cfg_in.ssrc            = csr_write_data;
            CSR_PAYLOAD_TYPE:    cfg_in.payload_type    = csr_write_data[6:0];
            default:             cfg_in                 = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_packet_size <= 16'd1400;
         cfg_ff.tcp_interleaved <= 1'b0;
         cfg_ff.ssrc            <= 32'd0;
         cfg_ff.payload_type    <= 7'd96;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end classifies each item and emits at most one job per item.
   h264rtp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .cfg      (cfg_ff),
      .q_status (q_status),
      .push     (push),
      .push_job (push_job)
   );

   h264rtp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_status (q_status)
   );

   // The back end walks each job's header bytes and its payload byte.
   h264rtp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .head_job (head_job),
      .q_status (q_status),
      .pop      (pop),
      .rsp_ch   (rsp_ch)
   );

endmodule
